// File: rtl/midi_message_transform_filter_assert.svh
// ----------------------------------------------------------------------------
// MIDI transform filter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_TRANSFORM_FILTER_ASSERT_SVH
`define MIDI_MESSAGE_TRANSFORM_FILTER_ASSERT_SVH

// same-cycle implication
`define MMTF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmtf assertion failed");

// next-cycle implication
`define MMTF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmtf assertion failed");

`endif

// File: rtl/mmtf_pkg.sv
// ----------------------------------------------------------------------------
// MIDI transform filter package
// Shared constants, item types and an arithmetic helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mmtf_pkg;

    localparam int CHAN_COUNT     = 16;
    localparam int CHAN_W         = $clog2(CHAN_COUNT);
    localparam int GAIN_FRAC_BITS = 6;
    localparam int GAIN_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [7:0] DATA_MAX     = 8'd127;
    localparam logic [7:0] OCTAVE       = 8'd12;
    localparam logic [7:0] NOTE_TOP_LOW = DATA_MAX - OCTAVE + 8'd1;
    localparam logic [7:0] VOLUME_RESET = 8'd100;
    localparam logic [7:0] VOLUME_CTL   = 8'd7;
    localparam logic [3:0] DRUM_CHANNEL = 4'd9;
    localparam logic [63:0] GAIN_RESET  = 64'h4040_4040_4040_4040;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CONTROL  = 4'hB;
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH_SHIFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH   = 3'd4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] status_byte;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic       discardable;
    } msg_t;

    typedef struct packed {
        logic [7:0] out_status;
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic       accepted;
    } res_t;

    typedef struct packed {
        logic signed [6:0]     pitch_shift;
        logic [CHAN_COUNT-1:0] mute_mask;
        logic [CHAN_COUNT-1:0] lock_mask;
        logic [63:0]           gain_low;
        logic [63:0]           gain_high;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [CHAN_W-1:0] addr;
        logic [7:0]        data;
    } vol_wr_t;

    // remainder by twelve through a reciprocal multiply, exact for x below 256
    function automatic logic [3:0] mod12(input logic [7:0] x);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = 16'(x) * 16'd171;
        q = p[15:11];
        r = x - {q, 3'b000} - {1'b0, q, 2'b00};
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/mmtf_in_if.sv
// ----------------------------------------------------------------------------
// MIDI transform filter input channel
// Valid/ready channel carrying one message item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmtf_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic       discardable;

    modport source (output valid, output cmd, output status_byte, output first_data,
                    output second_data, output discardable, input ready);
    modport sink   (input valid, input cmd, input status_byte, input first_data,
                    input second_data, input discardable, output ready);
endinterface

`default_nettype wire

// File: rtl/mmtf_out_if.sv
// ----------------------------------------------------------------------------
// MIDI transform filter result channel
// Valid/ready channel carrying one transformed message item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmtf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_status;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic       accepted;

    modport source (output valid, output out_status, output out_first, output out_second,
                    output accepted, input ready);
    modport sink   (input valid, input out_status, input out_first, input out_second,
                    input accepted, output ready);
endinterface

`default_nettype wire

// File: rtl/midi_message_transform_filter.sv
// ----------------------------------------------------------------------------
// MIDI message transform filter
// An accepted item is held in s1_item_reg, then its result in out_res_reg.
// Throughput: one item per cycle, bounded by the single read and write port
// of the volume memory; a stalled result blocks input only once the stage fills.
// Reset: config returns to defaults at once; volumes read as 100 until written,
// through per-channel valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_message_transform_filter_assert.svh"

module midi_message_transform_filter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    mmtf_in_if.sink                                  msg,
    mmtf_out_if.source                               result,
    input  wire logic                                cfg_we,
    input  wire logic [mmtf_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [mmtf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mmtf_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    msg_t     s1_item_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    res_t     out_res_reg;
    logic     accept;
    logic     s1_adv;
    msg_t     in_item;
    res_t     xres;
    logic     vol_upd;
    logic [7:0] vol_data;
    logic [7:0] stored_vol;
    vol_wr_t  vol_wr;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_PITCH_SHIFT: cfg_next.pitch_shift = signed'(cfg_data[6:0]);
                REG_MUTE_MASK:   cfg_next.mute_mask   = cfg_data[CHAN_COUNT-1:0];
                REG_LOCK_MASK:   cfg_next.lock_mask   = cfg_data[CHAN_COUNT-1:0];
                REG_GAIN_LOW:    cfg_next.gain_low    = cfg_data;
                REG_GAIN_HIGH:   cfg_next.gain_high   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    assign in_item = '{cmd:         msg.cmd,
                       status_byte: msg.status_byte,
                       first_data:  msg.first_data,
                       second_data: msg.second_data,
                       discardable: msg.discardable};

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign msg.ready = !s1_valid_reg || s1_adv;
    assign accept    = msg.valid && msg.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_shift <= '0;
            cfg_reg.mute_mask   <= '0;
            cfg_reg.lock_mask   <= '0;
            cfg_reg.gain_low    <= GAIN_RESET;
            cfg_reg.gain_high   <= GAIN_RESET;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_res_reg <= xres;
        end
    end

    assign vol_wr.en   = s1_adv && vol_upd;
    assign vol_wr.addr = s1_item_reg.status_byte[CHAN_W-1:0];
    assign vol_wr.data = vol_data;

    mmtf_vol_mem u_vol_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (msg.status_byte[CHAN_W-1:0]),
        .wr      (vol_wr),
        .rd_data (stored_vol)
    );

    mmtf_xform u_xform (
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .stored_vol (stored_vol),
        .res        (xres),
        .vol_upd    (vol_upd),
        .vol_data   (vol_data)
    );

    assign result.valid      = out_valid_reg;
    assign result.out_status = out_res_reg.out_status;
    assign result.out_first  = out_res_reg.out_first;
    assign result.out_second = out_res_reg.out_second;
    assign result.accepted   = out_res_reg.accepted;

    `MMTF_ASSERT_IMP(a_stall_blocks_input, s1_valid_reg && !s1_adv, !msg.ready)
    `MMTF_ASSERT_IMP(a_write_on_advance, vol_wr.en, s1_valid_reg && s1_adv)
    `MMTF_ASSERT_IMP(a_reject_zeroed, s1_adv && !xres.accepted,
                     xres.out_status == 8'd0 && xres.out_first == 8'd0 &&
                     xres.out_second == 8'd0)
    `MMTF_ASSERT_IMP(a_pass_status_kind, s1_adv && xres.accepted,
                     xres.out_status[7] && xres.out_status[7:4] != KIND_SYSTEM)
    `MMTF_ASSERT_NXT(a_advance_fills_output, s1_adv, out_valid_reg)

endmodule

`default_nettype wire

// File: rtl/mmtf_vol_mem.sv
// ----------------------------------------------------------------------------
// MIDI transform filter volume store
// Per-channel volume memory, registered read, write forwarding, valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mmtf_vol_mem (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [mmtf_pkg::CHAN_W-1:0] rd_addr,
    input  wire mmtf_pkg::vol_wr_t     wr,
    output logic [7:0]                 rd_data
);
    import mmtf_pkg::*;

    logic [7:0]            mem [CHAN_COUNT];
    logic [CHAN_COUNT-1:0] vld_reg;
    logic [CHAN_COUNT-1:0] vld_next;
    logic [7:0]            q_reg;
    logic                  q_vld_reg;
    logic                  fwd_hit_reg;
    logic [7:0]            fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (wr.en)
        begin
            vld_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            q_vld_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                q_vld_reg   <= vld_reg[rd_addr];
                fwd_hit_reg <= wr.en && (wr.addr == rd_addr);
            end
        end
    end

    // forward a write that lands on the edge of the read
    assign rd_data = fwd_hit_reg ? fwd_data_reg : (q_vld_reg ? q_reg : VOLUME_RESET);

endmodule

`default_nettype wire

// File: rtl/mmtf_xform.sv
// ----------------------------------------------------------------------------
// MIDI transform filter message datapath
// Refresh rewrite, volume scaling, note transpose and reject decision.
// ----------------------------------------------------------------------------
`default_nettype none

module mmtf_xform (
    input  wire mmtf_pkg::msg_t  item,
    input  wire mmtf_pkg::cfg_t  cfg,
    input  wire logic [7:0]      stored_vol,
    output mmtf_pkg::res_t       res,
    output logic                 vol_upd,
    output logic [7:0]           vol_data
);
    import mmtf_pkg::*;

    logic [CHAN_W-1:0]  ch;
    logic [7:0]         st;
    logic [7:0]         d1;
    logic [7:0]         d2;
    logic [3:0]         kind;
    logic [127:0]       gain_all;
    logic [7:0]         gain;
    logic [15:0]        prod;
    logic [15:0]        scaled;
    logic signed [9:0]  n;
    logic [7:0]         wrap_x;
    logic [3:0]         wrap_r;
    logic [7:0]         note;
    logic               is_note;
    logic               reject;
    logic [7:0]         o1;
    logic [7:0]         o2;

    always_comb
    begin
        ch = item.status_byte[CHAN_W-1:0];
        if (item.cmd)
        begin
            st = {KIND_CONTROL, item.status_byte[3:0]};
            d1 = VOLUME_CTL;
            d2 = stored_vol;
        end
        else
        begin
            st = item.status_byte;
            d1 = item.first_data;
            d2 = item.second_data;
        end
        kind = st[7:4];

        gain_all = {cfg.gain_high, cfg.gain_low};
        gain     = gain_all[{ch, 3'b000} +: GAIN_W];
        prod     = 16'(d2) * 16'(gain);
        scaled   = prod >> GAIN_FRAC_BITS;

        n = signed'({2'b00, d1}) + 10'(cfg.pitch_shift);
        if (n > signed'({2'b00, DATA_MAX}))
        begin
            wrap_x = 8'(n - signed'({2'b00, NOTE_TOP_LOW}));
        end
        else
        begin
            wrap_x = 8'(n + 10'sd72);
        end
        wrap_r = mod12(wrap_x);
        if (n > signed'({2'b00, DATA_MAX}))
        begin
            note = NOTE_TOP_LOW + 8'(wrap_r);
        end
        else if (n < 10'sd0)
        begin
            note = 8'(wrap_r);
        end
        else
        begin
            note = n[7:0];
        end

        is_note  = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON);
        vol_upd  = (kind == KIND_CONTROL) && (d1 == VOLUME_CTL);
        vol_data = d2;
        o1 = d1;
        o2 = d2;
        if (vol_upd)
        begin
            o2 = (scaled > 16'(DATA_MAX)) ? DATA_MAX : scaled[7:0];
        end
        else if (is_note && (item.status_byte[3:0] != DRUM_CHANNEL))
        begin
            o1 = note;
        end

        reject = !st[7] || (kind == KIND_SYSTEM) ||
                 (item.discardable && cfg.mute_mask[ch]) ||
                 (item.discardable && (kind == KIND_PROGRAM) && cfg.lock_mask[ch]);

        if (reject)
        begin
            res = '0;
        end
        else
        begin
            res.out_status = st;
            res.out_first  = o1;
            res.out_second = o2;
            res.accepted   = 1'b1;
        end
    end

endmodule

`default_nettype wire
